[rtl/min_subset_sum_difference_assert.svh]
// assertion macros for the min_subset_sum_difference checker
// expects signals named clk and rst_n in the scope of each use
`ifndef MIN_SUBSET_SUM_DIFFERENCE_ASSERT_SVH
`define MIN_SUBSET_SUM_DIFFERENCE_ASSERT_SVH

// same-cycle implication, off during reset
`define MSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_subset_sum_difference check failed");

// next-cycle implication, off during reset
`define MSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_subset_sum_difference check failed");

`endif

[rtl/mss_pkg.sv]
// shared constants for the minimum subset-sum difference block
// no dependencies
package mss_pkg;

    // default size of the reachable-sum store and of one set element
    localparam int MAX_SUM_DEFAULT    = 4096;
    localparam int VALUE_BITS_DEFAULT = 8;

    // width of the min_difference result port
    localparam int RESULT_BITS = 12;

endpackage

[rtl/mss_bit_ram.sv]
// one-bit-wide memory holding the reachable subset sums
// one write port, one read port with registered read data; no package use
module mss_bit_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic          wdata,
    input  logic [AW-1:0] raddr,
    output logic          rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/min_subset_sum_difference.sv]
// minimum subset-sum difference: top level with sequencer and shared address unit
// depends on mss_pkg and mss_bit_ram
//
// Set elements arrive one transaction at a time (start high while busy is low);
// last_item marks the final element. Reachable sums live in a one-bit memory with
// one read and one write per cycle, swept downward from the running total T: a
// non-zero element v that keeps the total within MAX_SUM-1 holds busy through the
// sweep and a flush step; an element above T also clears the stale entries
// between T and v. A zero element or one that overflows the store skips the sweep.
// After the last element a search walks down from half the total, one memory read
// a cycle, until it meets a reachable sum s. The result appears on min_difference
// and overflow for exactly one cycle with done high; the receiver cannot stall it,
// so it must capture the result in that cycle. An overflowed set reports
// overflow=1 with min_difference=0 in the cycle after its last element is accepted.
// The block then starts a fresh set with no clearing pass.
module min_subset_sum_difference #(
    parameter int MAX_SUM    = mss_pkg::MAX_SUM_DEFAULT,
    parameter int VALUE_BITS = mss_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [VALUE_BITS-1:0]           value,
    input  logic                            last_item,
    output logic                            done,
    output logic [mss_pkg::RESULT_BITS-1:0] min_difference,
    output logic                            overflow
);

    localparam int AW   = $clog2(MAX_SUM);
    localparam int SUMW = ((AW > VALUE_BITS) ? AW : VALUE_BITS) + 1;
    localparam int DW   = (AW > mss_pkg::RESULT_BITS) ? AW : mss_pkg::RESULT_BITS;
    localparam logic [SUMW-1:0] LIMIT_WIDE = SUMW'(MAX_SUM - 1);
    localparam logic [AW-1:0]   LIMIT      = AW'(MAX_SUM - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_SEARCH = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   total_reg, total_next;
    logic                            ovf_reg, ovf_next;
    logic [AW-1:0]                   v_reg, v_next;
    logic                            last_reg, last_next;
    logic [AW-1:0]                   addr_reg, addr_next;
    logic                            p_reg, p_next;
    logic [AW-1:0]                   pa_reg, pa_next;
    logic                            rz_reg;
    logic                            done_reg, done_next;
    logic [mss_pkg::RESULT_BITS-1:0] diff_reg, diff_next;
    logic                            ovf_out_reg, ovf_out_next;

    logic [SUMW-1:0] value_ext;
    logic [SUMW-1:0] sum_in;
    logic            in_ovf;
    logic            ram_rdata;
    logic            rd_bit;
    logic [AW-1:0]   wr_addr;
    logic            wr_en;
    logic [AW-1:0]   total_plus;
    logic [AW-1:0]   walk_end;
    logic [AW-1:0]   diff;
    logic [DW-1:0]   diff_ext;

    // incoming element against the store limit
    assign value_ext = SUMW'(value);
    assign sum_in    = SUMW'(total_reg) + value_ext;
    assign in_ovf    = ovf_reg | (sum_in > LIMIT_WIDE);

    // address zero is always reachable; reads that wrapped below zero see nothing
    assign rd_bit = (ram_rdata | rz_reg) & (pa_reg <= total_reg);

    // shared address unit: read address plus element gives write address
    assign wr_addr    = pa_reg + v_reg;
    assign total_plus = total_reg + v_reg;

    // walk stops at zero, or below it so every entry from T+1 up to v gets written
    assign walk_end = (v_reg > total_reg) ? (total_reg + 1'b1 - v_reg) : '0;

    // above the old total the entry is stale, so copy; below it only set
    assign wr_en = p_reg & ((state_reg == ST_WALK) | (state_reg == ST_FLUSH))
                 & (rd_bit | (wr_addr > total_reg));

    // difference for the sum found by the search
    assign diff     = total_reg - (pa_reg << 1);
    assign diff_ext = DW'(diff);

    mss_bit_ram #(
        .DEPTH (MAX_SUM),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (rd_bit),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        total_next   = total_reg;
        ovf_next     = ovf_reg;
        v_next       = v_reg;
        last_next    = last_reg;
        addr_next    = addr_reg;
        p_next       = 1'b0;
        pa_next      = pa_reg;
        done_next    = 1'b0;
        diff_next    = diff_reg;
        ovf_out_next = ovf_out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    v_next    = value_ext[AW-1:0];
                    last_next = last_item;
                    if (in_ovf)
                    begin
                        ovf_next   = 1'b1;
                        total_next = LIMIT;
                        if (last_item)
                        begin
                            done_next    = 1'b1;
                            diff_next    = '0;
                            ovf_out_next = 1'b1;
                            total_next   = '0;
                            ovf_next     = 1'b0;
                        end
                    end
                    else if (value_ext == '0)
                    begin
                        if (last_item)
                        begin
                            addr_next  = total_reg >> 1;
                            state_next = ST_SEARCH;
                        end
                    end
                    else
                    begin
                        addr_next  = total_reg;
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                p_next  = 1'b1;
                pa_next = addr_reg;
                if (addr_reg == walk_end)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    addr_next = addr_reg - 1'b1;
                end
            end
            ST_FLUSH:
            begin
                total_next = total_plus;
                if (last_reg)
                begin
                    addr_next  = total_plus >> 1;
                    state_next = ST_SEARCH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (p_reg && rd_bit)
                begin
                    done_next    = 1'b1;
                    diff_next    = diff_ext[mss_pkg::RESULT_BITS-1:0];
                    ovf_out_next = 1'b0;
                    total_next   = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    p_next  = 1'b1;
                    pa_next = addr_reg;
                    if (addr_reg != '0)
                    begin
                        addr_next = addr_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            p_reg     <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            p_reg     <= p_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        v_reg       <= v_next;
        last_reg    <= last_next;
        addr_reg    <= addr_next;
        pa_reg      <= pa_next;
        rz_reg      <= (addr_reg == '0);
        diff_reg    <= diff_next;
        ovf_out_reg <= ovf_out_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign min_difference = diff_reg;
    assign overflow       = ovf_out_reg;

endmodule

[rtl/mss_checker.sv]
// port-level checks for min_subset_sum_difference, bound to the top level
// depends on mss_pkg and min_subset_sum_difference_assert.svh
`include "min_subset_sum_difference_assert.svh"

module mss_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            last_item,
    input logic                            done,
    input logic [mss_pkg::RESULT_BITS-1:0] min_difference,
    input logic                            overflow
);

    // an overflowed set reports no difference
    `MSS_ASSERT_NOW(a_ovf_zero_diff, done && overflow, min_difference == '0)

    // a result is only shown once the block is back to taking transactions
    `MSS_ASSERT_NOW(a_done_not_busy, done, !busy)

    // an element that is not the last one never yields a result next cycle
    `MSS_ASSERT_NEXT(a_no_result_mid_set, start && !busy && !last_item, !done)

    // busy only rises after an accepted transaction
    `MSS_ASSERT_NOW(a_busy_from_start, $rose(busy), $past(start))

endmodule

bind min_subset_sum_difference mss_checker u_mss_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .last_item      (last_item),
    .done           (done),
    .min_difference (min_difference),
    .overflow       (overflow)
);

[verif/min_subset_sum_difference_tb.sv]
// self-checking testbench for the minimum subset-sum difference block
// depends on mss_pkg and the min_subset_sum_difference rtl
module min_subset_sum_difference_tb;

    localparam int SUM_LIMIT   = mss_pkg::MAX_SUM_DEFAULT;
    localparam int VAL_W       = mss_pkg::VALUE_BITS_DEFAULT;
    localparam int RES_W       = mss_pkg::RESULT_BITS;
    localparam int ITEM_TARGET = 1800;
    localparam int CYCLE_LIMIT = 6000000;
    localparam int ROW_COUNT   = 11;

    // one closing answer of a set
    typedef struct packed {
        logic [RES_W-1:0] diff;
        logic             ovf;
    } partition_t;

    // one row of the directed table, repeated reps times
    typedef struct packed {
        logic [VAL_W-1:0] elem;
        logic             is_last;
        logic [4:0]       reps;
        logic             typed;
        logic [RES_W-1:0] diff;
        logic             ovf;
    } step_row_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic [VAL_W-1:0] value     = '0;
    logic             last_item = 1'b0;
    logic             busy;
    logic             done;
    logic [RES_W-1:0] min_difference;
    logic             overflow;

    // predictor state: reachable subset sums, running total, saturation flag
    logic [SUM_LIMIT-1:0] sums_seen       = 1;
    int unsigned          running_total   = 0;
    bit                   total_saturated = 1'b0;

    partition_t  pending_partitions[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // directed sets: extremes, equal pair, zero element, overflow by one past the store
    step_row_t directed_rows [ROW_COUNT] = '{
        '{8'd0,   1'b1, 5'd1,  1'b1, 12'd0,   1'b0},
        '{8'd255, 1'b1, 5'd1,  1'b1, 12'd255, 1'b0},
        '{8'd1,   1'b1, 5'd1,  1'b1, 12'd1,   1'b0},
        '{8'd128, 1'b0, 5'd1,  1'b0, 12'd0,   1'b0},
        '{8'd128, 1'b1, 5'd1,  1'b1, 12'd0,   1'b0},
        '{8'd5,   1'b0, 5'd1,  1'b0, 12'd0,   1'b0},
        '{8'd0,   1'b0, 5'd1,  1'b0, 12'd0,   1'b0},
        '{8'd7,   1'b1, 5'd1,  1'b0, 12'd0,   1'b0},
        '{8'd255, 1'b0, 5'd16, 1'b0, 12'd0,   1'b0},
        '{8'd15,  1'b0, 5'd1,  1'b0, 12'd0,   1'b0},
        '{8'd1,   1'b1, 5'd1,  1'b1, 12'd0,   1'b1}
    };

    min_subset_sum_difference DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .value          (value),
        .last_item      (last_item),
        .done           (done),
        .min_difference (min_difference),
        .overflow       (overflow)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[min_subset_sum_difference] ERROR");
        $finish;
    end

    // fold one element into the reachable sums, close the set on the last one
    task automatic absorb_element(input logic [VAL_W-1:0] v, input logic lst,
                                  output bit closed, output partition_t res);
        int unsigned s;
        closed = 1'b0;
        res    = '0;
        if (v != 0)
            sums_seen = sums_seen | (sums_seen << v);
        if (running_total + v > SUM_LIMIT - 1)
        begin
            total_saturated = 1'b1;
            running_total   = SUM_LIMIT - 1;
        end
        else
            running_total += v;
        if (lst)
        begin
            closed = 1'b1;
            if (total_saturated)
            begin
                res.diff = '0;
                res.ovf  = 1'b1;
            end
            else
            begin
                // bit zero is always reachable, so the walk ends
                s = running_total / 2;
                while (s > 0 && !sums_seen[s])
                    s--;
                res.diff = RES_W'(running_total - 2 * s);
                res.ovf  = 1'b0;
            end
            sums_seen       = 1;
            running_total   = 0;
            total_saturated = 1'b0;
        end
    endtask

    // idle cycles before the next transaction, pct chance per cycle
    function automatic int idle_gap(input int pct);
        int n;
        n = 0;
        while (n < 40 && $urandom_range(0, 99) < pct)
            n++;
        return n;
    endfunction

    // one transaction; start stays high afterwards unless a gap follows
    task automatic send_element(input logic [VAL_W-1:0] v, input logic lst, input int gap,
                                output bit closed, output partition_t res);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        value     <= v;
        last_item <= lst;
        do
            @(posedge clk);
        while (busy);
        absorb_element(v, lst, closed, res);
    endtask

    // sender holds off until every pending answer has arrived
    task automatic drain_answers();
        start <= 1'b0;
        @(posedge clk);
        while (pending_partitions.size() != 0)
            @(posedge clk);
    endtask

    // compare each strobed answer with the oldest expectation
    always @(posedge clk)
    begin : check_answers
        partition_t want;
        if (rst_n && done)
        begin
            if (pending_partitions.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected answer: diff=%0d ovf=%0b", min_difference, overflow);
                mismatches++;
            end
            else
            begin
                want = pending_partitions.pop_front();
                if (want.diff !== min_difference || want.ovf !== overflow)
                begin
                    if (mismatches < 10)
                        $display("answer mismatch: expected diff=%0d ovf=%0b, got diff=%0d ovf=%0b",
                                 want.diff, want.ovf, min_difference, overflow);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        bit               closed;
        partition_t       res;
        int               items;
        int               phase;
        int               pct;
        int               kind;
        int               set_len;
        logic [VAL_W-1:0] v;
        items = 0;
        phase = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            for (int k = 0; k < directed_rows[r].reps; k++)
            begin
                send_element(directed_rows[r].elem,
                             directed_rows[r].is_last && k == directed_rows[r].reps - 1,
                             idle_gap(6), closed, res);
                if (closed)
                begin
                    if (directed_rows[r].typed)
                        pending_partitions.push_back('{directed_rows[r].diff,
                                                       directed_rows[r].ovf});
                    else
                        pending_partitions.push_back(res);
                end
            end
        end
        drain_answers();

        // random sets, mostly small totals to keep the sweeps short
        while (items < ITEM_TARGET)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 2)
                set_len = $urandom_range(15, 19);
            else if (kind < 22)
                set_len = $urandom_range(1, 4);
            else
                set_len = $urandom_range(1, 10);
            for (int k = 0; k < set_len; k++)
            begin
                // idling profile changes by thirds, with a full drain at each change
                if (items >= 2 * ITEM_TARGET / 3 && phase == 1)
                begin
                    phase = 2;
                    drain_answers();
                end
                else if (items >= ITEM_TARGET / 3 && phase == 0)
                begin
                    phase = 1;
                    drain_answers();
                end
                pct = (phase == 0) ? 6 : (phase == 1) ? 49 : 0;
                if (kind < 2)
                    v = VAL_W'($urandom_range(224, 255));
                else if (kind < 22)
                    v = VAL_W'($urandom_range(0, 255));
                else if ($urandom_range(0, 9) == 0)
                    v = '0;
                else
                    v = VAL_W'($urandom_range(1, 31));
                send_element(v, k == set_len - 1, idle_gap(pct), closed, res);
                if (closed)
                    pending_partitions.push_back(res);
                items++;
            end
        end

        // wrap up
        start <= 1'b0;
        @(posedge clk);
        while (pending_partitions.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("[min_subset_sum_difference] OK");
        else
            $display("[min_subset_sum_difference] ERROR");
        $finish;
    end

endmodule
